// ===== hw/rtl/dnarc_pkg.sv =====
// Shared types, character codes and base-pairing function for the reverse complement block.
`default_nettype none

package dnarc_pkg;

  typedef logic [7:0] char_t;
  typedef logic [1:0] status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  localparam char_t CH_NL   = 8'h0A;
  localparam char_t CH_GAP  = 8'h2D;
  localparam char_t CH_UA   = 8'h41;
  localparam char_t CH_UZ   = 8'h5A;
  localparam char_t CH_LA   = 8'h61;
  localparam char_t CH_LZ   = 8'h7A;
  localparam char_t CASE_OFFSET = 8'h20;
  localparam char_t CH_NULL = 8'h00;

  localparam char_t PAIR_NONE   = 8'h00;
  localparam char_t PAIR_TRIPLE = 8'h01;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BAD    = 2'd1;
  localparam status_t ST_TRIPLE = 2'd2;
  localparam status_t ST_LONG   = 2'd3;

  function automatic char_t pair_of(input char_t c);
    char_t p;
    case (c)
      "A": p = "T";
      "T": p = "A";
      "U": p = "A";
      "C": p = "G";
      "G": p = "C";
      "R": p = "Y";
      "Y": p = "R";
      "K": p = "M";
      "M": p = "K";
      "S": p = "S";
      "W": p = "W";
      "N": p = "N";
      "B", "D", "H", "V": p = PAIR_TRIPLE;
      default: p = PAIR_NONE;
    endcase
    return p;
  endfunction

  function automatic char_t complement_of(input char_t c);
    return (c == CH_GAP) ? CH_GAP : pair_of(c);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dnarc_if.sv =====
// Valid/ready channel interfaces for the character input and the base output.
`default_nettype none

interface dnarc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       final_char;

  modport source (output valid, output symbol, output final_char, input ready);
  modport sink (input valid, input symbol, input final_char, output ready);
endinterface

interface dnarc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] base;
  logic       has_base;
  logic [1:0] status;
  logic       run_end;

  modport source (output valid, output base, output has_base, output status,
                  output run_end, input ready);
  modport sink (input valid, input base, input has_base, input status,
                input run_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dnarc_cell.sv =====
// One stack cell: holds a character and shifts it deeper on push or shallower on pop.
`default_nettype none

module dnarc_cell
  import dnarc_pkg::*;
(
  input  wire        clk,
  input  cell_ctrl_t ctrl,
  input  char_t      push_in,
  input  char_t      pop_in,
  output char_t      data_out
);

  char_t data_r;
  char_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      data_nxt = push_in;
    end else if (ctrl.pop) begin
      data_nxt = pop_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dna_reverse_complement.sv =====
// Top level: stacks a DNA sequence in a chain of cells and emits its reverse complement.
//
//   channel   dir   handshake         payload
//   in_ch     in    valid / ready     symbol[7:0], final_char
//   out_ch    out   valid / ready     base[7:0], has_base, status[1:0], run_end
//
// Characters load at one item per cycle while no sequence is being emitted.
// A final item of a valid sequence of n characters is followed by n results,
// each from one pop of the cell chain; an error or empty sequence gives
// one result in the cycle after the final item. Reset is synchronous and
// clears only control state, so the block is ready in the cycle after reset.
// A low out_ch.ready while a result is pending holds the output register and stalls both pops and loads.
`default_nettype none

module dna_reverse_complement
  import dnarc_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  dnarc_in_if.sink     in_ch,
  dnarc_out_if.source  out_ch
);

  localparam int FILL_W = $clog2(MAX_LEN + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_LEN);
  localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);
  localparam logic [FILL_W-1:0] FILL_ZERO = '0;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  status_t           err_r, err_nxt;
  logic              ended_r, ended_nxt;
  logic              letters_r, letters_nxt;

  logic              out_valid_r, out_valid_nxt;
  char_t             base_r, base_nxt;
  logic              has_base_r, has_base_nxt;
  status_t           status_r, status_nxt;
  logic              run_end_r, run_end_nxt;

  cell_ctrl_t        ctrl;
  char_t             chain_q [MAX_LEN];
  char_t             c_up;
  char_t             pair;
  logic              out_free;
  logic              in_acc;
  logic              load_out;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
      char_t push_src;
      char_t pop_src;
      if (gi == 0) begin : g_head
        assign push_src = c_up;
      end else begin : g_body
        assign push_src = chain_q[gi-1];
      end
      if (gi == MAX_LEN - 1) begin : g_tail
        assign pop_src = CH_NULL;
      end else begin : g_link
        assign pop_src = chain_q[gi+1];
      end
      dnarc_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .push_in  (push_src),
        .pop_in   (pop_src),
        .data_out (chain_q[gi])
      );
    end
  endgenerate

  assign c_up = (in_ch.symbol inside {[CH_LA:CH_LZ]}) ? (in_ch.symbol - CASE_OFFSET)
                                                       : in_ch.symbol;
  assign pair     = pair_of(c_up);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_LOAD) && out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    err_nxt      = err_r;
    ended_nxt    = ended_r;
    letters_nxt  = letters_r;
    ctrl         = '0;
    load_out     = 1'b0;
    base_nxt     = base_r;
    has_base_nxt = has_base_r;
    status_nxt   = status_r;
    run_end_nxt  = run_end_r;

    if (in_acc) begin
      if (!ended_r) begin
        if (in_ch.symbol == CH_NL) begin
          ended_nxt = 1'b1;
        end else if (fill_r >= FILL_MAX) begin
          err_nxt = ST_LONG;
        end else begin
          ctrl.push = 1'b1;
          fill_nxt  = fill_r + FILL_ONE;
          if (err_r == ST_LONG || c_up == CH_GAP) begin
            err_nxt = err_r;
          end else if (!(c_up inside {[CH_UA:CH_UZ]})) begin
            letters_nxt = 1'b0;
            err_nxt     = ST_BAD;
          end else if (letters_r && pair == PAIR_NONE) begin
            err_nxt = ST_BAD;
          end else if (letters_r && pair == PAIR_TRIPLE) begin
            err_nxt = ST_TRIPLE;
          end
        end
      end
      if (in_ch.final_char) begin
        if (err_nxt != ST_OK || fill_nxt == FILL_ZERO) begin
          load_out     = 1'b1;
          base_nxt     = CH_NULL;
          has_base_nxt = 1'b0;
          status_nxt   = err_nxt;
          run_end_nxt  = 1'b1;
          fill_nxt     = FILL_ZERO;
        end else begin
          state_nxt = ST_EMIT;
        end
        err_nxt     = ST_OK;
        ended_nxt   = 1'b0;
        letters_nxt = 1'b1;
      end
    end else if (state_r == ST_EMIT && out_free) begin
      ctrl.pop     = 1'b1;
      load_out     = 1'b1;
      base_nxt     = complement_of(chain_q[0]);
      has_base_nxt = 1'b1;
      status_nxt   = ST_OK;
      run_end_nxt  = (fill_r == FILL_ONE);
      fill_nxt     = fill_r - FILL_ONE;
      if (fill_r == FILL_ONE) begin
        state_nxt = ST_LOAD;
      end
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= FILL_ZERO;
      err_r       <= ST_OK;
      ended_r     <= 1'b0;
      letters_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      err_r       <= err_nxt;
      ended_r     <= ended_nxt;
      letters_r   <= letters_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    has_base_r <= has_base_nxt;
    status_r   <= status_nxt;
    run_end_r  <= run_end_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.base     = base_r;
  assign out_ch.has_base = has_base_r;
  assign out_ch.status   = status_r;
  assign out_ch.run_end  = run_end_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("stack fill count exceeds its depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> fill_r != FILL_ZERO)
    else $error("emitting from an empty stack");

  a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.pop && fill_r == FILL_ONE) |=> (state_r == ST_LOAD && out_ch.run_end))
    else $error("last pop did not end the sequence");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (!out_ch.has_base && out_ch.run_end))
    else $error("error item carries a base or is not the last item");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.push && ctrl.pop))
    else $error("push and pop in the same cycle");

endmodule

`default_nettype wire

// ===== tb/dna_reverse_complement_tb.sv =====
// Self-checking testbench for the DNA reverse complement block, with a table and a random part.
`timescale 1ns / 1ps

module dna_reverse_complement_tb
  import dnarc_pkg::*;
();

  localparam int MAX_LEN     = 64;
  localparam int N_DIR       = 26;
  localparam int RAND_ITEMS  = 340;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    char_t   base;
    logic    has_base;
    status_t status;
    logic    run_end;
  } rc_result_t;

  typedef struct packed {
    char_t   sym;
    logic    fin;
    logic    typed;
    status_t want;
  } dir_row_t;

  typedef enum {SEQ_CLEAN, SEQ_FAULTY, SEQ_NEWLINE, SEQ_NOISE} seq_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  dnarc_in_if  in_ch ();
  dnarc_out_if out_ch ();

  dna_reverse_complement #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  rc_result_t  expected_bases[$];
  rc_result_t  head_res;
  int unsigned fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned sent_items = 0;
  int          stall_pct  = 6;

  char_t       seq_stack[MAX_LEN];
  int unsigned seq_depth;
  status_t     seq_err;
  bit          seq_nl_seen;
  bit          seq_letters_only;

  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{CH_NL,   1'b1, 1'b1, ST_OK},
    '{"a",     1'b1, 1'b0, ST_OK},
    '{"g",     1'b0, 1'b0, ST_OK},
    '{"C",     1'b0, 1'b0, ST_OK},
    '{CH_GAP,  1'b0, 1'b0, ST_OK},
    '{"u",     1'b0, 1'b0, ST_OK},
    '{"r",     1'b0, 1'b0, ST_OK},
    '{"Y",     1'b1, 1'b0, ST_OK},
    '{"k",     1'b0, 1'b0, ST_OK},
    '{"m",     1'b0, 1'b0, ST_OK},
    '{"s",     1'b0, 1'b0, ST_OK},
    '{"w",     1'b0, 1'b0, ST_OK},
    '{"n",     1'b0, 1'b0, ST_OK},
    '{"T",     1'b1, 1'b0, ST_OK},
    '{"B",     1'b1, 1'b1, ST_TRIPLE},
    '{"D",     1'b0, 1'b0, ST_OK},
    '{8'hFF,   1'b0, 1'b0, ST_OK},
    '{"v",     1'b1, 1'b1, ST_BAD},
    '{"E",     1'b0, 1'b0, ST_OK},
    '{"b",     1'b1, 1'b1, ST_TRIPLE},
    '{"h",     1'b0, 1'b0, ST_OK},
    '{"z",     1'b1, 1'b1, ST_BAD},
    '{"A",     1'b0, 1'b0, ST_OK},
    '{CH_NL,   1'b0, 1'b0, ST_OK},
    '{"%",     1'b0, 1'b0, ST_OK},
    '{"Q",     1'b1, 1'b0, ST_OK}
  };

  function automatic char_t iupac_mate(input char_t c);
    string plain = "ACGTURYKMSWN";
    string mates = "TGCAAYRMKSWN";
    string triple = "BDHV";
    for (int i = 0; i < plain.len(); i++) begin
      if (char_t'(plain[i]) == c) return char_t'(mates[i]);
    end
    for (int i = 0; i < triple.len(); i++) begin
      if (char_t'(triple[i]) == c) return PAIR_TRIPLE;
    end
    return PAIR_NONE;
  endfunction

  function automatic void seq_clear();
    seq_depth        = 0;
    seq_err          = ST_OK;
    seq_nl_seen      = 1'b0;
    seq_letters_only = 1'b1;
  endfunction

  function automatic void stack_char(input char_t sym);
    char_t c;
    char_t m;
    c = sym;
    if (c >= CH_LA && c <= CH_LZ) c = c - CASE_OFFSET;
    if (seq_depth >= MAX_LEN) begin
      seq_err = ST_LONG;
      return;
    end
    seq_stack[seq_depth] = c;
    seq_depth++;
    if (seq_err == ST_LONG || c == CH_GAP) return;
    if (c < CH_UA || c > CH_UZ) begin
      seq_letters_only = 1'b0;
      seq_err = ST_BAD;
      return;
    end
    if (seq_letters_only) begin
      m = iupac_mate(c);
      if (m == PAIR_NONE) seq_err = ST_BAD;
      else if (m == PAIR_TRIPLE) seq_err = ST_TRIPLE;
    end
  endfunction

  function automatic void revcomp_step(input char_t sym, input bit fin,
                                       ref rc_result_t res[$]);
    char_t c;
    if (!seq_nl_seen) begin
      if (sym == CH_NL) seq_nl_seen = 1'b1;
      else stack_char(sym);
    end
    if (!fin) return;
    if (seq_err != ST_OK || seq_depth == 0) begin
      res.push_back('{CH_NULL, 1'b0, seq_err, 1'b1});
    end else begin
      for (int k = 0; k < seq_depth; k++) begin
        c = seq_stack[seq_depth - 1 - k];
        res.push_back('{(c == CH_GAP) ? CH_GAP : iupac_mate(c), 1'b1, ST_OK,
                        (k == seq_depth - 1)});
      end
    end
    seq_clear();
  endfunction

  function automatic char_t clean_char();
    string alpha = "ACGTURYKMSWN-";
    char_t c;
    c = char_t'(alpha[$urandom_range(0, alpha.len() - 1)]);
    if (c != CH_GAP && $urandom_range(0, 1) == 1) c = c + CASE_OFFSET;
    return c;
  endfunction

  function automatic char_t fault_char();
    string bad = "BDHVEFIJLOPQXZbdhvez@[`{";
    if ($urandom_range(0, 2) == 0) return char_t'($urandom_range(0, 255));
    return char_t'(bad[$urandom_range(0, bad.len() - 1)]);
  endfunction

  task automatic send_item(input char_t sym, input bit fin, input bit typed,
                           input status_t want);
    rc_result_t got[$];
    while ($urandom_range(0, 99) < stall_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.symbol     <= sym;
    in_ch.final_char <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
    revcomp_step(sym, fin, got);
    if (typed) begin
      expected_bases.push_back('{CH_NULL, 1'b0, want, 1'b1});
    end else begin
      foreach (got[i]) expected_bases.push_back(got[i]);
    end
  endtask

  task automatic send_sequence(input seq_kind_t kind, input int len);
    int    bad_pos;
    int    junk;
    char_t c;
    case (kind)
      SEQ_CLEAN: begin
        for (int i = 0; i < len; i++) send_item(clean_char(), i == len - 1, 1'b0, ST_OK);
      end
      SEQ_FAULTY: begin
        bad_pos = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
          c = (i == bad_pos) ? fault_char() : clean_char();
          send_item(c, i == len - 1, 1'b0, ST_OK);
        end
      end
      SEQ_NEWLINE: begin
        junk = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) send_item(clean_char(), 1'b0, 1'b0, ST_OK);
        send_item(CH_NL, junk == 0, 1'b0, ST_OK);
        for (int i = 0; i < junk; i++) begin
          send_item(char_t'($urandom_range(0, 255)), i == junk - 1, 1'b0, ST_OK);
        end
      end
      default: begin
        for (int i = 0; i < len; i++) begin
          send_item(char_t'($urandom_range(0, 255)), i == len - 1, 1'b0, ST_OK);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bases.size() == 0) begin
        $error("unexpected result: base %h has_base %b status %0d run_end %b",
               out_ch.base, out_ch.has_base, out_ch.status, out_ch.run_end);
        fail_cnt++;
      end else begin
        head_res = expected_bases.pop_front();
        if (out_ch.base !== head_res.base) begin
          $error("base: expected %h, actual %h", head_res.base, out_ch.base);
          fail_cnt++;
        end
        if (out_ch.has_base !== head_res.has_base) begin
          $error("has_base: expected %b, actual %b", head_res.has_base, out_ch.has_base);
          fail_cnt++;
        end
        if (out_ch.status !== head_res.status) begin
          $error("status: expected %0d, actual %0d", head_res.status, out_ch.status);
          fail_cnt++;
        end
        if (out_ch.run_end !== head_res.run_end) begin
          $error("run_end: expected %b, actual %b", head_res.run_end, out_ch.run_end);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    seq_kind_t kind;
    int        len;
    int        roll;
    int        seq_idx;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.symbol     <= CH_NULL;
    in_ch.final_char <= 1'b0;
    seq_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_item(dir_rows[i].sym, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
    end

    seq_idx = 0;
    while (sent_items < N_DIR + RAND_ITEMS) begin
      stall_pct = (seq_idx >= 8 && seq_idx < 16) ? 0 : 6;
      if (seq_idx == 0) begin
        kind = SEQ_CLEAN;
        len  = MAX_LEN;
      end else if (seq_idx == 1) begin
        kind = SEQ_CLEAN;
        len  = MAX_LEN + 1;
      end else if (seq_idx == 2) begin
        kind = SEQ_NEWLINE;
        len  = MAX_LEN + 2;
      end else begin
        roll = $urandom_range(0, 99);
        kind = (roll < 65) ? SEQ_CLEAN : (roll < 77) ? SEQ_FAULTY :
               (roll < 89) ? SEQ_NEWLINE : SEQ_NOISE;
        len  = ($urandom_range(0, 11) == 0) ? $urandom_range(30, MAX_LEN + 2)
                                             : $urandom_range(1, 10);
        if (kind == SEQ_NEWLINE && $urandom_range(0, 4) == 0) len = 0;
      end
      send_sequence(kind, len);
      seq_idx++;
    end
    stall_pct   = 6;
    in_ch.valid <= 1'b0;

    while (expected_bases.size() != 0) @(posedge clk);
    repeat (2 * MAX_LEN) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
